// ----- rtl/sjis_pkg.sv -----
`default_nettype none

package sjis_pkg;

    // Default depth of the mapping table.
    localparam int TABLE_DEPTH_DEF = 8192;

    // Fixed field widths of the interface.
    localparam int INDEX_W = 13;
    localparam int CODE_W  = 16;
    localparam int COUNT_W = 14;

    // Command queue between the classifier and the execution side.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // Operation codes of an input word.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DATA = 1'b1;

    // Byte classes of Shift_JIS.
    localparam logic [7:0]  NUL_CHAR   = 8'h00;
    localparam logic [7:0]  ASCII_MAX  = 8'h7F;
    localparam logic [7:0]  KANA_FIRST = 8'hA1;
    localparam logic [7:0]  KANA_LAST  = 8'hDF;
    localparam logic [15:0] KANA_BASE  = 16'hFF61;

    // Replacement character '?'.
    localparam logic [15:0] REPLACE_CHAR = 16'h003F;

    // UTF-8 encoding limits and marker bits.
    localparam logic [15:0] UTF8_2BYTE_MIN = 16'h0080;
    localparam logic [15:0] UTF8_3BYTE_MIN = 16'h0800;
    localparam logic [7:0]  UTF8_CONT      = 8'h80;
    localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_EMIT,
        CMD_LOOKUP
    } cmd_kind_t;

    // One queued command. A load uses index, key and value; an emit carries
    // its code point in value; a lookup carries the two-byte code in key.
    typedef struct packed {
        cmd_kind_t           kind;
        logic [INDEX_W-1:0]  index;
        logic [CODE_W-1:0]   key;
        logic [CODE_W-1:0]   value;
    } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/sjis_front.sv -----
`default_nettype none

module sjis_front
    import sjis_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_stall,
    input  wire                op,
    input  wire [INDEX_W-1:0]  entry_index,
    input  wire [CODE_W-1:0]   entry_key,
    input  wire [CODE_W-1:0]   entry_unicode,
    input  wire [7:0]          data_byte,
    input  wire                last_of_string,
    input  wire                queue_full,
    output logic               push,
    output cmd_t               push_cmd
);

    logic       accept;
    logic       pending_reg;
    logic       pending_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    logic       stopped_reg;
    logic       stopped_next;

    assign in_stall = queue_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        pending_next   = pending_reg;
        held_next      = held_reg;
        stopped_next   = stopped_reg;
        push           = 1'b0;
        push_cmd.kind  = CMD_LOAD;
        push_cmd.index = entry_index;
        push_cmd.key   = entry_key;
        push_cmd.value = entry_unicode;

        if (accept)
        begin
            if (op == OP_LOAD)
            begin
                push = 1'b1;
            end
            else
            begin
                if (stopped_reg)
                begin
                    // Rest of the string after a NUL is dropped.
                end
                else if (pending_reg)
                begin
                    push          = 1'b1;
                    push_cmd.kind = CMD_LOOKUP;
                    push_cmd.key  = {held_reg, data_byte};
                    pending_next  = 1'b0;
                    held_next     = '0;
                end
                else if (data_byte == NUL_CHAR)
                begin
                    stopped_next = 1'b1;
                end
                else if (data_byte <= ASCII_MAX)
                begin
                    push           = 1'b1;
                    push_cmd.kind  = CMD_EMIT;
                    push_cmd.value = {8'h00, data_byte};
                end
                else if (data_byte inside {[KANA_FIRST:KANA_LAST]})
                begin
                    push           = 1'b1;
                    push_cmd.kind  = CMD_EMIT;
                    push_cmd.value = KANA_BASE + {8'h00, data_byte} - {8'h00, KANA_FIRST};
                end
                else if (last_of_string)
                begin
                    push           = 1'b1;
                    push_cmd.kind  = CMD_EMIT;
                    push_cmd.value = REPLACE_CHAR;
                end
                else
                begin
                    pending_next = 1'b1;
                    held_next    = data_byte;
                end

                if (last_of_string)
                begin
                    pending_next = 1'b0;
                    held_next    = '0;
                    stopped_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            held_reg    <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            held_reg    <= held_next;
            stopped_reg <= stopped_next;
        end
    end

    // A string end always leaves the classifier with a clean slate.
    a_string_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == OP_DATA && last_of_string |=> !pending_reg && !stopped_reg)
        else $error("string state not cleared after last byte");

endmodule

`default_nettype wire

// ----- rtl/sjis_fifo.sv -----
`default_nettype none

module sjis_fifo
    import sjis_pkg::*;
(
    input  wire   clk,
    input  wire   rst_n,
    input  wire   push,
    input  cmd_t  push_cmd,
    output logic  full,
    input  wire   pop,
    output cmd_t  pop_cmd,
    output logic  empty
);

    cmd_t                   entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg;

    assign full    = count_reg == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign pop_cmd = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("command queue popped while empty");

    a_fill_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("command queue fill count lost a push");

endmodule

`default_nettype wire

// ----- rtl/sjis_back.sv -----
`default_nettype none

module sjis_back
    import sjis_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_valid,
    input  wire [COUNT_W-1:0]  entries_in_use,
    input  wire                queue_empty,
    output logic               queue_pop,
    input  cmd_t               queue_cmd,
    output logic               out_valid,
    input  wire                out_stall,
    output logic [7:0]         utf8_byte,
    output logic               last_of_run
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_ENCODE
    } state_t;

    logic [31:0]        map_store [TABLE_DEPTH];
    logic [31:0]        rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;

    logic [COUNT_W-1:0] entries_reg;
    logic [CW-1:0]      hi_start;

    state_t             state_reg;
    state_t             state_next;
    logic [CW-1:0]      lo_reg;
    logic [CW-1:0]      lo_next;
    logic [CW-1:0]      hi_reg;
    logic [CW-1:0]      hi_next;
    logic [CW-1:0]      mid_reg;
    logic [CW-1:0]      mid_next;
    logic [CODE_W-1:0]  key_reg;
    logic [CODE_W-1:0]  key_next;
    logic [CODE_W-1:0]  cp_reg;
    logic [CODE_W-1:0]  cp_next;
    logic [1:0]         byte_idx_reg;
    logic [1:0]         byte_idx_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [7:0]         out_byte_reg;
    logic [7:0]         out_byte_next;
    logic               out_last_reg;
    logic               out_last_next;

    logic               out_free;
    logic [CODE_W-1:0]  probe_key;
    logic [CODE_W-1:0]  probe_code;
    logic [CW-1:0]      mid_plus;
    logic [CW:0]        sum_up;
    logic [CW:0]        sum_dn;
    logic [CW-1:0]      mid_up;
    logic [CW-1:0]      mid_dn;
    logic [1:0]         nbytes;
    logic [7:0]         enc_byte;

    assign out_valid   = out_valid_reg;
    assign utf8_byte   = out_byte_reg;
    assign last_of_run = out_last_reg;
    assign out_free    = !out_valid_reg || !out_stall;

    // Counts above the table depth are treated as the full table.
    assign hi_start = (EW'(entries_reg) > EW'(TABLE_DEPTH)) ?
                      CW'(TABLE_DEPTH) : CW'(entries_reg);

    // Both possible next probes are formed in parallel with the key compare.
    assign probe_key  = rd_data_reg[31:16];
    assign probe_code = rd_data_reg[15:0];
    assign mid_plus   = mid_reg + 1'b1;
    assign sum_up     = {1'b0, mid_plus} + {1'b0, hi_reg};
    assign sum_dn     = {1'b0, lo_reg} + {1'b0, mid_reg};
    assign mid_up     = sum_up[CW:1];
    assign mid_dn     = sum_dn[CW:1];

    assign wr_addr = AW'(queue_cmd.index);

    always_comb
    begin
        if (cp_reg < UTF8_2BYTE_MIN)
        begin
            nbytes = 2'd1;
        end
        else if (cp_reg < UTF8_3BYTE_MIN)
        begin
            nbytes = 2'd2;
        end
        else
        begin
            nbytes = 2'd3;
        end
    end

    always_comb
    begin
        case (nbytes)
            2'd2:
            begin
                enc_byte = (byte_idx_reg == 2'd0) ?
                           (UTF8_LEAD2 | {3'b000, cp_reg[10:6]}) :
                           (UTF8_CONT | {2'b00, cp_reg[5:0]});
            end
            2'd3:
            begin
                case (byte_idx_reg)
                    2'd0:    enc_byte = UTF8_LEAD3 | {4'b0000, cp_reg[15:12]};
                    2'd1:    enc_byte = UTF8_CONT | {2'b00, cp_reg[11:6]};
                    default: enc_byte = UTF8_CONT | {2'b00, cp_reg[5:0]};
                endcase
            end
            default:
            begin
                enc_byte = cp_reg[7:0];
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        cp_next        = cp_reg;
        byte_idx_next  = byte_idx_reg;
        out_valid_next = out_free ? 1'b0 : out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        queue_pop      = 1'b0;
        wr_en          = 1'b0;
        rd_addr        = AW'(mid_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    queue_pop = 1'b1;
                    case (queue_cmd.kind)
                        CMD_LOAD:
                        begin
                            wr_en = IW'(queue_cmd.index) < IW'(TABLE_DEPTH);
                        end
                        CMD_EMIT:
                        begin
                            cp_next       = queue_cmd.value;
                            byte_idx_next = '0;
                            state_next    = ST_ENCODE;
                        end
                        CMD_LOOKUP:
                        begin
                            key_next      = queue_cmd.key;
                            lo_next       = '0;
                            hi_next       = hi_start;
                            mid_next      = hi_start >> 1;
                            rd_addr       = AW'(hi_start >> 1);
                            byte_idx_next = '0;
                            if (hi_start == '0)
                            begin
                                cp_next    = REPLACE_CHAR;
                                state_next = ST_ENCODE;
                            end
                            else
                            begin
                                state_next = ST_SEARCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SEARCH:
            begin
                if (probe_key == key_reg)
                begin
                    cp_next    = (probe_code != '0) ? probe_code : REPLACE_CHAR;
                    state_next = ST_ENCODE;
                end
                else if (probe_key < key_reg)
                begin
                    lo_next  = mid_plus;
                    mid_next = mid_up;
                    rd_addr  = AW'(mid_up);
                    if (!(mid_plus < hi_reg))
                    begin
                        cp_next    = REPLACE_CHAR;
                        state_next = ST_ENCODE;
                    end
                end
                else
                begin
                    hi_next  = mid_reg;
                    mid_next = mid_dn;
                    rd_addr  = AW'(mid_dn);
                    if (!(lo_reg < mid_reg))
                    begin
                        cp_next    = REPLACE_CHAR;
                        state_next = ST_ENCODE;
                    end
                end
            end

            ST_ENCODE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = enc_byte;
                    out_last_next  = byte_idx_reg == (nbytes - 2'd1);
                    if (byte_idx_reg == (nbytes - 2'd1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        byte_idx_next = byte_idx_reg + 2'd1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Table memory: one write port for loads, one registered read port for
    // the search.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_store[wr_addr] <= {queue_cmd.key, queue_cmd.value};
        end
        rd_data_reg <= map_store[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= '0;
        end
        else if (cfg_valid)
        begin
            entries_reg <= entries_in_use;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            byte_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            byte_idx_reg  <= byte_idx_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            mid_reg       <= mid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        cp_reg       <= cp_next;
        out_byte_reg <= out_byte_next;
    end

    // The probe always lies inside the live search window.
    a_probe_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEARCH |-> lo_reg <= mid_reg && mid_reg < hi_reg)
        else $error("binary search probe outside its window");

    a_byte_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ENCODE |-> byte_idx_reg < nbytes)
        else $error("UTF-8 byte index past sequence length");

endmodule

`default_nettype wire

// ----- rtl/shift_jis_to_utf8_converter_top.sv -----
`default_nettype none

// An ASCII or kana byte passes through the command queue, the code point register and the output
// register before its first output word shows. The execution side takes one command at a time;
// a two-byte code runs a binary search of at most ceil(log2(entries + 1)) probes (14 for 8192),
// made one at a time through the single registered read port of the table memory.
// Reset (rst_n, asynchronous, active low) clears all control state and the entry count; the
// table contents are not cleared and must be loaded before use.

module shift_jis_to_utf8_converter_top
    import sjis_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire                clk,
    input  wire                rst_n,

    // Input word channel: load words and string data bytes.
    input  wire                in_valid,
    output logic               in_stall,
    input  wire                op,
    input  wire [INDEX_W-1:0]  entry_index,
    input  wire [CODE_W-1:0]   entry_key,
    input  wire [CODE_W-1:0]   entry_unicode,
    input  wire [7:0]          data_byte,
    input  wire                last_of_string,

    // Output word channel: one UTF-8 byte per word.
    output logic               out_valid,
    input  wire                out_stall,
    output logic [7:0]         utf8_byte,
    output logic               last_of_run,

    // Configuration write channel for the entry count.
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire [COUNT_W-1:0]  entries_in_use
);

    logic queue_full;
    logic queue_empty;
    logic queue_push;
    logic queue_pop;
    cmd_t push_cmd;
    cmd_t pop_cmd;

    // The entry count register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    // The front end classifies each input word: loads and direct characters go
    // straight to the queue, a lead byte is held until its trail byte arrives
    // and then turns into a lookup command, or into '?' if it ends the string.
    // NUL, the rest of a stopped string and a held lead byte never reach the queue.
    sjis_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .entry_index    (entry_index),
        .entry_key      (entry_key),
        .entry_unicode  (entry_unicode),
        .data_byte      (data_byte),
        .last_of_string (last_of_string),
        .queue_full     (queue_full),
        .push           (queue_push),
        .push_cmd       (push_cmd)
    );

    // A short command queue lets the front keep taking words while the back
    // end searches the table or waits on a stalled output.
    sjis_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (queue_push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (queue_pop),
        .pop_cmd  (pop_cmd),
        .empty    (queue_empty)
    );

    // The back end owns the table memory: it writes loads, runs the binary
    // search one probe per cycle, and serializes the code point as UTF-8
    // through a registered output stage.
    sjis_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid && cfg_ready),
        .entries_in_use (entries_in_use),
        .queue_empty    (queue_empty),
        .queue_pop      (queue_pop),
        .queue_cmd      (pop_cmd),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .utf8_byte      (utf8_byte),
        .last_of_run    (last_of_run)
    );

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
module testbench;
    import sjis_pkg::*;

    localparam int DEPTH      = TABLE_DEPTH_DEF;
    localparam int DRAIN      = 40;    // cycles of rest after every owed output word has arrived
    localparam int QUIET_MAX  = 2000;  // cycles without any handshake before giving up
    localparam int IDLE_PCT   = 27;

    // Tracks the converter state and the UTF-8 bytes it owes.
    class utf8_tracker;
        bit [31:0] code_map [0:DEPTH-1];
        int        map_count;
        bit [7:0]  held_lead;
        bit        lead_held;
        bit        stopped;
        bit [8:0]  pending_utf8[$];   // {last_of_run, utf8_byte}
        int        errors;
        int        data_words;
        int        load_words;
        int        utf8_checked;
        int        lookup_hits;
        int        lookup_misses;

        function bit [15:0] find_code_point(bit [15:0] key);
            int        lo;
            int        hi;
            int        mid;
            bit [31:0] slot;
            lo = 0;
            hi = (map_count > DEPTH) ? DEPTH : map_count;
            while (lo < hi)
            begin
                mid  = (lo + hi) / 2;
                slot = code_map[mid];
                if (slot[31:16] == key)
                    return slot[15:0];
                if (slot[31:16] < key)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            return 16'h0000;
        endfunction

        function void owe_byte(bit [8:0] w);
            pending_utf8.insert(pending_utf8.size(), w);
        endfunction

        function void push_code(bit [15:0] cp);
            if (cp < UTF8_2BYTE_MIN)
            begin
                owe_byte({1'b1, cp[7:0]});
            end
            else if (cp < UTF8_3BYTE_MIN)
            begin
                owe_byte({1'b0, UTF8_LEAD2 | {3'b000, cp[10:6]}});
                owe_byte({1'b1, UTF8_CONT | {2'b00, cp[5:0]}});
            end
            else
            begin
                owe_byte({1'b0, UTF8_LEAD3 | {4'b0000, cp[15:12]}});
                owe_byte({1'b0, UTF8_CONT | {2'b00, cp[11:6]}});
                owe_byte({1'b1, UTF8_CONT | {2'b00, cp[5:0]}});
            end
        endfunction

        function void set_count(bit [COUNT_W-1:0] n);
            map_count = int'(n);
        endfunction

        // Called for every input word the block takes.
        function void decode_sjis(bit o, bit [INDEX_W-1:0] idx, bit [CODE_W-1:0] key,
                                  bit [CODE_W-1:0] uni, bit [7:0] c, bit last);
            bit [15:0] cp;
            if (o == OP_LOAD)
            begin
                load_words++;
                code_map[idx] = {key, uni};
                return;
            end
            data_words++;
            if (stopped)
            begin
                // Rest of the string after a NUL is dropped.
            end
            else if (lead_held)
            begin
                cp        = find_code_point({held_lead, c});
                lead_held = 1'b0;
                held_lead = 8'h00;
                if (cp != 16'h0000)
                    lookup_hits++;
                else
                    lookup_misses++;
                push_code((cp != 16'h0000) ? cp : REPLACE_CHAR);
            end
            else if (c == NUL_CHAR)
                stopped = 1'b1;
            else if (c <= ASCII_MAX)
                push_code({8'h00, c});
            else if (c >= KANA_FIRST && c <= KANA_LAST)
                push_code(KANA_BASE + 16'(c - KANA_FIRST));
            else if (last)
                push_code(REPLACE_CHAR);
            else
            begin
                held_lead = c;
                lead_held = 1'b1;
            end
            if (last)
            begin
                held_lead = 8'h00;
                lead_held = 1'b0;
                stopped   = 1'b0;
            end
        endfunction

        // Called for every output word the block hands over.
        function void match_utf8(bit [7:0] b, bit last);
            bit [8:0] want;
            if (pending_utf8.size() == 0)
            begin
                $display("%0t: unexpected output word, utf8_byte %02h last_of_run %0b",
                         $time, b, last);
                errors++;
                return;
            end
            want = pending_utf8.pop_front();
            utf8_checked++;
            if (want[7:0] != b)
            begin
                $display("%0t: utf8_byte expected %02h, actual %02h", $time, want[7:0], b);
                errors++;
            end
            if (want[8] != last)
            begin
                $display("%0t: last_of_run expected %0b, actual %0b", $time, want[8], last);
                errors++;
            end
        endfunction
    endclass

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                in_valid       = 1'b0;
    logic                in_stall;
    logic                op             = OP_LOAD;
    logic [INDEX_W-1:0]  entry_index    = '0;
    logic [CODE_W-1:0]   entry_key      = '0;
    logic [CODE_W-1:0]   entry_unicode  = '0;
    logic [7:0]          data_byte      = 8'h00;
    logic                last_of_string = 1'b0;
    logic                out_valid;
    logic                out_stall      = 1'b0;
    logic [7:0]          utf8_byte;
    logic                last_of_run;
    logic                cfg_valid      = 1'b0;
    logic                cfg_ready;
    logic [COUNT_W-1:0]  entries_in_use = '0;

    utf8_tracker tracker;
    bit          calm = 1'b0;          // while set, neither side inserts idle cycles
    int          quiet_cycles = 0;
    bit [15:0]   loaded_keys [0:DEPTH-1];
    int          loaded_n = 0;
    int          sizes [4];

    shift_jis_to_utf8_converter_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .entry_index    (entry_index),
        .entry_key      (entry_key),
        .entry_unicode  (entry_unicode),
        .data_byte      (data_byte),
        .last_of_string (last_of_string),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .utf8_byte      (utf8_byte),
        .last_of_run    (last_of_run),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .entries_in_use (entries_in_use)
    );

    always #5 clk = ~clk;

    wire in_take  = in_valid && !in_stall;
    wire out_take = out_valid && !out_stall;
    wire cfg_take = cfg_valid && cfg_ready;

    // The output side stalls at random, except inside the calm stretch.
    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Every output word the block hands over is checked in order.
    always @(posedge clk)
    begin
        if (rst_n && out_take)
            tracker.match_utf8(utf8_byte, last_of_run);
    end

    // A stretch with no handshake at all on any channel means the block hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_take || out_take || cfg_take)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_MAX)
            begin
                $display("%0t: no progress, %0d output words still owed",
                         $time, tracker.pending_utf8.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Presents one input word, idling first at random, and returns after the
    // edge that takes it. Valid stays high so a following word runs back to back.
    task automatic send_word(input bit o, input bit [INDEX_W-1:0] idx,
                             input bit [CODE_W-1:0] key, input bit [CODE_W-1:0] uni,
                             input bit [7:0] c, input bit last);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        op             <= o;
        entry_index    <= idx;
        entry_key      <= key;
        entry_unicode  <= uni;
        data_byte      <= c;
        last_of_string <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.decode_sjis(o, idx, key, uni, c, last);
    endtask

    task automatic send_load(input int idx, input bit [15:0] key, input bit [15:0] uni);
        send_word(OP_LOAD, INDEX_W'(idx), key, uni, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic send_data(input bit [7:0] c, input bit last);
        send_word(OP_DATA, INDEX_W'($urandom_range(0, DEPTH - 1)),
                  CODE_W'($urandom_range(0, 65535)), CODE_W'($urandom_range(0, 65535)),
                  c, last);
    endtask

    // Lowers valid and waits until every owed output word has arrived.
    task automatic wait_results();
        in_valid <= 1'b0;
        while (tracker.pending_utf8.size() != 0)
            @(posedge clk);
    endtask

    // Brings the block to rest so that the entry count may change.
    task automatic settle();
        wait_results();
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_count(input bit [COUNT_W-1:0] n);
        cfg_valid      <= 1'b1;
        entries_in_use <= n;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tracker.set_count(n);
    endtask

    function automatic bit [15:0] rand_code_point();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'h0000;
        if (r < 30)
            return 16'($urandom_range(1, 'h7F));
        if (r < 60)
            return 16'($urandom_range('h80, 'h7FF));
        return 16'($urandom_range('h800, 'hFFFF));
    endfunction

    function automatic bit [7:0] rand_lead();
        if ($urandom_range(0, 1) == 1)
            return 8'($urandom_range('h80, 'hA0));
        return 8'($urandom_range('hE0, 'hFF));
    endfunction

    function automatic bit is_lead(bit [7:0] b);
        return (b > ASCII_MAX) && !(b >= KANA_FIRST && b <= KANA_LAST);
    endfunction

    // Picks a loaded key, preferring one whose high byte really is a lead byte.
    function automatic bit [15:0] pick_key();
        bit [15:0] key;
        key = loaded_keys[$urandom_range(0, loaded_n - 1)];
        for (int t = 0; t < 8 && !is_lead(key[15:8]); t++)
            key = loaded_keys[$urandom_range(0, loaded_n - 1)];
        return key;
    endfunction

    // Fills slots 0..n-1 with strictly rising keys spread over the whole code space.
    task automatic load_table(input int n);
        int step;
        step     = 65536 / n;
        loaded_n = n;
        for (int i = 0; i < n; i++)
        begin
            loaded_keys[i] = 16'(i * step + $urandom_range(0, step - 1));
            send_load(i, loaded_keys[i], rand_code_point());
        end
    endtask

    // Rewrites the code point of a loaded slot, keeping the table sorted.
    task automatic refresh_entry();
        int idx;
        idx = $urandom_range(0, loaded_n - 1);
        send_load(idx, loaded_keys[idx], rand_code_point());
    endtask

    // One random Shift_JIS string: mostly well-formed characters and table hits,
    // with some unknown pairs, NUL bytes, raw noise and the odd dangling lead byte.
    task automatic send_text();
        bit [7:0]  seq[$];
        bit [15:0] key;
        int        r;
        repeat ($urandom_range(1, 4))
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                seq.insert(seq.size(), 8'($urandom_range(1, 'h7F)));
            else if (r < 30)
                seq.insert(seq.size(), 8'($urandom_range(KANA_FIRST, KANA_LAST)));
            else if (r < 65)
            begin
                key = pick_key();
                seq.insert(seq.size(), key[15:8]);
                seq.insert(seq.size(), key[7:0]);
            end
            else if (r < 75)
            begin
                seq.insert(seq.size(), rand_lead());
                seq.insert(seq.size(), 8'($urandom_range(0, 255)));
            end
            else if (r < 80)
                seq.insert(seq.size(), NUL_CHAR);
            else
                seq.insert(seq.size(), 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0)
            seq.insert(seq.size(), rand_lead());
        foreach (seq[i])
        begin
            if ($urandom_range(0, 99) < 4)
                refresh_entry();
            send_data(seq[i], i == seq.size() - 1);
        end
    endtask

    initial
    begin
        tracker = new;
        sizes   = '{1, 7, 40, 64};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: plain characters, and a pair that must miss with no entries.
        write_count(0);
        send_data(8'h41, 1'b0);
        send_data(8'h7F, 1'b0);
        send_data(8'hA1, 1'b0);
        send_data(8'hDF, 1'b0);
        send_data(8'h81, 1'b0);
        send_data(8'h40, 1'b0);
        send_data(8'h80, 1'b1);       // lead byte closing the string
        send_data(NUL_CHAR, 1'b0);    // NUL stops the string
        send_data(8'h42, 1'b0);
        send_data(8'h43, 1'b1);
        send_data(8'hFF, 1'b0);
        send_data(NUL_CHAR, 1'b1);    // NUL taken as the trail byte
        settle();

        // Small hand-made table covering every length of UTF-8 encoding.
        send_load(0,  16'h0000, 16'h0041);
        send_load(1,  16'h8140, 16'h3000);
        send_load(2,  16'h8145, 16'h0000);
        send_load(3,  16'h8150, 16'h00A7);
        send_load(4,  16'h8160, 16'h007E);
        send_load(5,  16'h8200, 16'h07FF);
        send_load(6,  16'h8201, 16'h0800);
        send_load(7,  16'h8240, 16'h0080);
        send_load(8,  16'h889F, 16'h4E9C);
        send_load(9,  16'h9000, 16'h0001);
        send_load(10, 16'hA040, 16'h00FF);
        send_load(11, 16'hE040, 16'h6F3E);
        send_load(12, 16'hEAA4, 16'h7199);
        send_load(13, 16'hF040, 16'hE000);
        send_load(14, 16'hFC4B, 16'hFFFE);
        send_load(15, 16'hFFFF, 16'hFFFF);
        send_load(DEPTH - 1, 16'hFFFF, 16'h0000);
        for (int i = 0; i < 16; i++)
            loaded_keys[i] = tracker.code_map[i][31:16];
        loaded_n = 16;
        settle();
        write_count(16);
        send_data(8'h81, 1'b0);
        send_data(8'h40, 1'b0);       // three-byte result
        send_data(8'h81, 1'b0);
        send_data(8'h45, 1'b0);       // zero code point
        send_data(8'h82, 1'b0);
        send_data(NUL_CHAR, 1'b0);    // trail byte of zero that hits
        send_data(8'h82, 1'b0);
        send_load(7, 16'h8240, 16'h0100);   // load while a lead byte is held
        send_data(8'h40, 1'b0);
        send_data(8'hFF, 1'b0);
        send_data(8'hFF, 1'b0);
        send_data(8'h81, 1'b0);
        send_data(8'h41, 1'b1);       // miss
        settle();

        // Random strings over tables of rising size; the last table runs with no idling.
        for (int p = 0; p < 4; p++)
        begin
            calm = (p == 3);
            load_table(sizes[p]);
            settle();
            write_count(COUNT_W'(sizes[p]));
            for (int s = 0; s < 8; s++)
            begin
                send_text();
                if (sizes[p] == 40 && s == 3)
                    wait_results();
            end
            calm = 1'b0;
            settle();
        end

        wait_results();
        repeat (DRAIN) @(posedge clk);
        $display("Covered %0d data bytes and %0d table loads, entry counts 0 to %0d.",
                 tracker.data_words, tracker.load_words, sizes[3]);
        $display("Checked %0d UTF-8 bytes; pair lookups: %0d hits, %0d misses.",
                 tracker.utf8_checked, tracker.lookup_hits, tracker.lookup_misses);
        if (tracker.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- shift_jis_to_utf8_converter_top.f -----
rtl/sjis_pkg.sv
rtl/sjis_front.sv
rtl/sjis_fifo.sv
rtl/sjis_back.sv
rtl/shift_jis_to_utf8_converter_top.sv
test/testbench.sv
